// ----- hw/rtl/ccfd_pkg.sv -----
package ccfd_pkg;

  // Parser phase; encodings above PH_LF fall back to hunting.
  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_Z       = 4'd1,
    PH_H       = 4'd2,
    PH_TYPE    = 4'd3,
    PH_HDR     = 4'd4,
    PH_LEN_LO  = 4'd5,
    PH_LEN_HI  = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_CRC_LO  = 4'd8,
    PH_CRC_HI  = 4'd9,
    PH_CR      = 4'd10,
    PH_LF      = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_WRONG_TYPE = 3'd1,
    ST_CRC_BAD    = 3'd2,
    ST_BAD_TAIL   = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_t;

  // Configuration register indexes
  localparam logic CFG_EXPECTED_TYPE = 1'b0;
  localparam logic CFG_MAX_PAYLOAD   = 1'b1;

  localparam logic [7:0]  CHAR_AT   = 8'h40;
  localparam logic [7:0]  CHAR_Z    = 8'h5A;
  localparam logic [7:0]  CHAR_H    = 8'h48;
  localparam logic [7:0]  CHAR_CR   = 8'h0D;
  localparam logic [7:0]  CHAR_LF   = 8'h0A;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  TYPE_RST  = 8'h50;
  localparam logic [15:0] MAXLEN_RST = 16'd1024;

  // CRC-16/MODBUS, one byte, LSB first
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_AFTER_AT = crc16_feed(CRC_INIT, CHAR_AT);

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        payload_valid;
    logic        payload_last;
    logic        frame_done;
    status_t     frame_status;
    logic [15:0] payload_length;
    logic [31:0] header_word;
  } result_t;

endpackage

// ----- hw/rtl/crc_checked_frame_deframer.sv -----
// Each result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one byte per cycle while the skid entry is empty; the path that sets it is the 8-step
//   CRC-16 byte update plus phase decode in ccfd_parser, between state and output register.
// Reset (rst, synchronous, active high): parser hunts for '@', CRC = 0xFFFF,
//   expected_type = 0x50, max_payload_len = 1024, output and skid registers empty.
module crc_checked_frame_deframer
  import ccfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] out_byte, [23:8] payload_length, [55:24] header_word
  output logic        m_tlast,   // payload_last
  output logic [4:0]  m_tuser,   // [0] payload_valid, [1] frame_done, [4:2] frame_status
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic    in_fire;
  logic    out_fire;
  logic    res_valid;
  result_t res;

  // Output register plus one skid entry. s_tready depends only on the
  // skid flag, so there is no combinational path from m_tready back to s_tready.
  logic    out_valid;
  result_t out_res;
  logic    skid_valid;
  result_t skid_res;

  assign s_tready = !skid_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = out_valid && m_tready;

  ccfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(in_fire),
    .data_byte (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  // Control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // no input is taken while the skid entry is full
      if (out_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_fire) begin
      out_valid <= in_fire && res_valid;
    end else if (in_fire && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_res <= skid_res;
      end
    end else if (!out_valid || out_fire) begin
      out_res <= res;
    end else begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.header_word, out_res.payload_length, out_res.out_byte};
  assign m_tlast  = out_res.payload_last;
  assign m_tuser  = {out_res.frame_status, out_res.frame_done, out_res.payload_valid};

  // The skid entry is only ever filled behind a pending output transaction.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry full while output register empty");

  // A held skid entry stays until the output drains.
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !m_tready |=> skid_valid)
    else $error("skid entry dropped without output transaction");

  // tlast only on a payload result, never on a status result.
  a_last_is_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0] && !m_tuser[1])
    else $error("tlast on a non-payload result");

  // A result is either a payload byte or a frame status, never both or neither.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] != m_tuser[1]))
    else $error("result kind flags inconsistent");

endmodule

// ----- hw/rtl/ccfd_parser.sv -----
module ccfd_parser
  import ccfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic [7:0]  data_byte,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        res_valid,
  output result_t     res
);

  logic [7:0]  expected_type;
  logic [15:0] max_payload_len;

  phase_t      phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] declared_length, declared_length_next;
  logic [31:0] header_bytes, header_bytes_next;
  logic [7:0]  received_crc_low, received_crc_low_next;

  logic [15:0] crc_upd;
  logic [15:0] pos_inc;
  logic        pay_last;
  logic [15:0] len_full;
  logic        crc_ok;

  assign crc_upd  = crc16_feed(running_crc, data_byte);
  assign pos_inc  = byte_position + 16'd1;
  assign pay_last = ({1'b0, byte_position} + 17'd1) >= {1'b0, declared_length};
  assign len_full = {data_byte, declared_length[7:0]};
  assign crc_ok   = (received_crc_low == running_crc[7:0]) &&
                    (data_byte == running_crc[15:8]);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_type   <= TYPE_RST;
      max_payload_len <= MAXLEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_TYPE: expected_type   <= cfg_data[7:0];
        CFG_MAX_PAYLOAD:   max_payload_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    running_crc_next      = running_crc;
    declared_length_next  = declared_length;
    header_bytes_next     = header_bytes;
    received_crc_low_next = received_crc_low;
    case (phase)
      PH_Z, PH_H: begin
        if ((phase == PH_Z && data_byte == CHAR_Z) ||
            (phase == PH_H && data_byte == CHAR_H)) begin
          running_crc_next = crc_upd;
          phase_next       = (phase == PH_Z) ? PH_H : PH_TYPE;
        end else if (data_byte == CHAR_AT) begin
          phase_next            = PH_Z;
          byte_position_next    = '0;
          declared_length_next  = '0;
          header_bytes_next     = '0;
          received_crc_low_next = '0;
          running_crc_next      = CRC_AFTER_AT;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_TYPE: begin
        if (data_byte != expected_type) begin
          phase_next = PH_HUNT;
        end else begin
          running_crc_next   = crc_upd;
          byte_position_next = '0;
          phase_next         = PH_HDR;
        end
      end
      PH_HDR: begin
        running_crc_next = crc_upd;
        case (byte_position[1:0])
          2'd0: header_bytes_next[7:0]   = header_bytes[7:0]   | data_byte;
          2'd1: header_bytes_next[15:8]  = header_bytes[15:8]  | data_byte;
          2'd2: header_bytes_next[23:16] = header_bytes[23:16] | data_byte;
          default: header_bytes_next[31:24] = header_bytes[31:24] | data_byte;
        endcase
        byte_position_next = pos_inc;
        if (pos_inc >= 16'd4) begin
          phase_next = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        running_crc_next     = crc_upd;
        declared_length_next = {8'h00, data_byte};
        phase_next           = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        running_crc_next     = crc_upd;
        declared_length_next = len_full;
        if (len_full > max_payload_len) begin
          phase_next = PH_HUNT;
        end else begin
          byte_position_next = '0;
          phase_next         = (len_full == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_crc_next   = crc_upd;
        byte_position_next = pos_inc;
        if (pay_last) begin
          phase_next = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        received_crc_low_next = data_byte;
        phase_next            = PH_CRC_HI;
      end
      PH_CRC_HI: phase_next = crc_ok ? PH_CR : PH_HUNT;
      PH_CR:     phase_next = (data_byte == CHAR_CR) ? PH_LF : PH_HUNT;
      PH_LF:     phase_next = PH_HUNT;
      default: begin
        if (data_byte == CHAR_AT) begin
          phase_next            = PH_Z;
          byte_position_next    = '0;
          declared_length_next  = '0;
          header_bytes_next     = '0;
          received_crc_low_next = '0;
          running_crc_next      = CRC_AFTER_AT;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  // result for the byte being taken
  always_comb begin
    res_valid          = 1'b0;
    res.out_byte       = '0;
    res.payload_valid  = 1'b0;
    res.payload_last   = 1'b0;
    res.frame_done     = 1'b0;
    res.frame_status   = ST_OK;
    res.payload_length = declared_length;
    res.header_word    = header_bytes;
    case (phase)
      PH_TYPE: begin
        if (data_byte != expected_type) begin
          res_valid        = 1'b1;
          res.frame_done   = 1'b1;
          res.frame_status = ST_WRONG_TYPE;
        end
      end
      PH_LEN_HI: begin
        res.payload_length = len_full;
        if (len_full > max_payload_len) begin
          res_valid        = 1'b1;
          res.frame_done   = 1'b1;
          res.frame_status = ST_TOO_LONG;
        end
      end
      PH_PAYLOAD: begin
        res_valid         = 1'b1;
        res.out_byte      = data_byte;
        res.payload_valid = 1'b1;
        res.payload_last  = pay_last;
      end
      PH_CRC_HI: begin
        if (!crc_ok) begin
          res_valid        = 1'b1;
          res.frame_done   = 1'b1;
          res.frame_status = ST_CRC_BAD;
        end
      end
      PH_CR: begin
        if (data_byte != CHAR_CR) begin
          res_valid        = 1'b1;
          res.frame_done   = 1'b1;
          res.frame_status = ST_BAD_TAIL;
        end
      end
      PH_LF: begin
        res_valid        = 1'b1;
        res.frame_done   = 1'b1;
        res.frame_status = (data_byte == CHAR_LF) ? ST_OK : ST_BAD_TAIL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      byte_position    <= '0;
      running_crc      <= CRC_INIT;
      declared_length  <= '0;
      header_bytes     <= '0;
      received_crc_low <= '0;
    end else if (byte_valid) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      running_crc      <= running_crc_next;
      declared_length  <= declared_length_next;
      header_bytes     <= header_bytes_next;
      received_crc_low <= received_crc_low_next;
    end
  end

endmodule
